[rtl/block_credit_ring_queue_defines.svh]
// Assertion macros shared by the credit ring queue RTL.
`ifndef BLOCK_CREDIT_RING_QUEUE_DEFINES_SVH
`define BLOCK_CREDIT_RING_QUEUE_DEFINES_SVH

// Implication in the same cycle, clocked on clk_i, quiet during reset.
`define BCRQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define BCRQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bcrq_pkg.sv]
// Types and constants of the credit ring queue.
package bcrq_pkg;

  typedef enum logic [1:0] {
    REQ_ENQ    = 2'd0,
    REQ_DEQ    = 2'd1,
    REQ_PERMIT = 2'd2,
    REQ_READS  = 2'd3
  } bcrq_req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BLOCKED = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_ZERO    = 2'd3
  } bcrq_status_e;

  localparam logic [6:0] GRANT_RESET = 7'd16;

  typedef struct packed {
    bcrq_req_e   req_type;
    logic [63:0] item_data;
    logic [3:0]  block_index;
    logic [7:0]  read_total;
  } bcrq_in_t;

  typedef struct packed {
    bcrq_status_e status;
    logic [63:0]  out_data;
    logic [3:0]   out_block;
    logic [6:0]   permits_granted;
  } bcrq_out_t;

endpackage

[rtl/bcrq_slot_ram.sv]
// Slot store: one write port, registered read of the head slot, clearing sweep after reset.
module bcrq_slot_ram #(
  parameter int QUEUE_DEPTH = 1024,
  localparam int SW = $clog2(QUEUE_DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [SW-1:0] waddr_i,
  input  logic [63:0]   wdata_i,
  input  logic [SW-1:0] raddr_i,
  output logic [63:0]   head_o,
  output logic          busy_o
);
  import bcrq_pkg::*;

  logic [63:0]   mem [QUEUE_DEPTH];
  logic [63:0]   rdata_q;
  logic [63:0]   byp_data_q;
  logic          byp_q;
  logic          clr_q, clr_d;
  logic [SW-1:0] clr_cnt_q, clr_cnt_d;
  logic          we;
  logic [SW-1:0] waddr;
  logic [63:0]   wdata;

  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == SW'(QUEUE_DEPTH - 1)) begin
        clr_d     = 1'b0;
        clr_cnt_d = '0;
      end
    end
  end

  assign we    = clr_q | we_i;
  assign waddr = clr_q ? clr_cnt_q : waddr_i;
  assign wdata = clr_q ? 64'd0 : wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // Read-first array; a write to the slot being read is forwarded.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q    <= mem[raddr_i];
    byp_q      <= we && (waddr == raddr_i);
    byp_data_q <= wdata;
  end

  assign head_o = byp_q ? byp_data_q : rdata_q;
  assign busy_o = clr_q;

endmodule

[rtl/bcrq_core.sv]
// Request execution: ring positions, block read counts, permit pool and grant register.
module bcrq_core #(
  parameter int QUEUE_DEPTH = 1024,
  parameter int BLOCK_LEN   = 64,
  localparam int SW = $clog2(QUEUE_DEPTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                exec_i,
  input  bcrq_pkg::bcrq_in_t  req_i,
  input  logic [63:0]         head_i,
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_wdata_i,
  output bcrq_pkg::bcrq_out_t rsp_o,
  output logic                mem_we_o,
  output logic [SW-1:0]       mem_waddr_o,
  output logic [63:0]         mem_wdata_o,
  output logic [SW-1:0]       mem_raddr_o
);
  import bcrq_pkg::*;

  localparam int NUM_BLOCKS = (QUEUE_DEPTH + BLOCK_LEN - 1) / BLOCK_LEN;
  // Only the first sixteen blocks can ever receive read counts.
  localparam int NB_ST = (NUM_BLOCKS < 16) ? NUM_BLOCKS : 16;
  localparam int OW = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
  localparam int BW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int IW = (NB_ST > 1) ? $clog2(NB_ST) : 1;
  localparam int TW = 32 + $clog2(BLOCK_LEN + 1);

  logic [31:0]   wpos_q, wpos_d, rpos_q, rpos_d;
  logic [SW-1:0] wslot_q, wslot_d, rslot_q, rslot_d;
  logic [OW-1:0] woff_q, woff_d, roff_q, roff_d;
  logic [BW-1:0] wblk_q, wblk_d, rblk_q, rblk_d;
  logic [TW-1:0] wthr_q, wthr_d;  // write lap times block length
  logic [31:0]   br_q [NB_ST];
  logic [31:0]   br_d [NB_ST];
  logic [31:0]   pool_q, pool_d;
  logic [6:0]    grant_q;
  logic [31:0]   br_sel;
  logic [32:0]   pool_sum;
  logic [6:0]    granted;
  logic          w_adv, r_adv;

  assign br_sel   = (32'(wblk_q) < NB_ST) ? br_q[wblk_q[IW-1:0]] : 32'd0;
  assign pool_sum = {1'b0, pool_q} + 33'(BLOCK_LEN);
  assign granted  = (32'(grant_q) < pool_q) ? grant_q : pool_q[6:0];

  always_comb begin
    rsp_o       = '0;
    rsp_o.status = ST_OK;
    mem_we_o    = 1'b0;
    mem_waddr_o = wslot_q;
    mem_wdata_o = req_i.item_data;
    pool_d      = pool_q;
    br_d        = br_q;
    w_adv       = 1'b0;
    r_adv       = 1'b0;
    case (req_i.req_type)
      REQ_ENQ: begin
        if (req_i.item_data == 64'd0) begin
          rsp_o.status = ST_ZERO;
        end else if (TW'(br_sel) < wthr_q) begin
          rsp_o.status = ST_BLOCKED;
        end else begin
          mem_we_o = exec_i;
          w_adv    = 1'b1;
          if (woff_q == '0) begin
            pool_d = pool_sum[32] ? 32'hFFFF_FFFF : pool_sum[31:0];
          end
        end
      end
      REQ_DEQ: begin
        if (head_i == 64'd0) begin
          rsp_o.status = ST_EMPTY;
        end else begin
          rsp_o.out_data  = head_i;
          rsp_o.out_block = 4'(rblk_q);
          mem_we_o        = exec_i;
          mem_waddr_o     = rslot_q;
          mem_wdata_o     = 64'd0;
          r_adv           = 1'b1;
        end
      end
      REQ_PERMIT: begin
        rsp_o.permits_granted = granted;
        pool_d = pool_q - 32'(granted);
      end
      default: begin
        if (32'(req_i.block_index) < NB_ST) begin
          br_d[req_i.block_index[IW-1:0]] =
            br_q[req_i.block_index[IW-1:0]] + 32'(req_i.read_total);
        end
      end
    endcase
  end

  // Write position advance; the 32-bit wrap restarts at slot zero, lap zero.
  always_comb begin
    wpos_d  = wpos_q;
    wslot_d = wslot_q;
    woff_d  = woff_q;
    wblk_d  = wblk_q;
    wthr_d  = wthr_q;
    if (exec_i && w_adv) begin
      wpos_d = wpos_q + 32'd1;
      if (wpos_q == 32'hFFFF_FFFF) begin
        wslot_d = '0;
        woff_d  = '0;
        wblk_d  = '0;
        wthr_d  = '0;
      end else if (wslot_q == SW'(QUEUE_DEPTH - 1)) begin
        wslot_d = '0;
        woff_d  = '0;
        wblk_d  = '0;
        wthr_d  = wthr_q + TW'(BLOCK_LEN);
      end else begin
        wslot_d = wslot_q + 1'b1;
        if (woff_q == OW'(BLOCK_LEN - 1)) begin
          woff_d = '0;
          wblk_d = wblk_q + 1'b1;
        end else begin
          woff_d = woff_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    rpos_d  = rpos_q;
    rslot_d = rslot_q;
    roff_d  = roff_q;
    rblk_d  = rblk_q;
    if (exec_i && r_adv) begin
      rpos_d = rpos_q + 32'd1;
      if (rpos_q == 32'hFFFF_FFFF || rslot_q == SW'(QUEUE_DEPTH - 1)) begin
        rslot_d = '0;
        roff_d  = '0;
        rblk_d  = '0;
      end else begin
        rslot_d = rslot_q + 1'b1;
        if (roff_q == OW'(BLOCK_LEN - 1)) begin
          roff_d = '0;
          rblk_d = rblk_q + 1'b1;
        end else begin
          roff_d = roff_q + 1'b1;
        end
      end
    end
  end

  // Head slot is fetched for the position that holds after this request.
  assign mem_raddr_o = rslot_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q  <= '0;
      wslot_q <= '0;
      woff_q  <= '0;
      wblk_q  <= '0;
      wthr_q  <= '0;
      rpos_q  <= '0;
      rslot_q <= '0;
      roff_q  <= '0;
      rblk_q  <= '0;
      pool_q  <= '0;
      grant_q <= GRANT_RESET;
      for (int i = 0; i < NB_ST; i++) begin
        br_q[i] <= '0;
      end
    end else begin
      wpos_q  <= wpos_d;
      wslot_q <= wslot_d;
      woff_q  <= woff_d;
      wblk_q  <= wblk_d;
      wthr_q  <= wthr_d;
      rpos_q  <= rpos_d;
      rslot_q <= rslot_d;
      roff_q  <= roff_d;
      rblk_q  <= rblk_d;
      if (exec_i) begin
        pool_q <= pool_d;
        br_q   <= br_d;
      end
      if (cfg_we_i) begin
        grant_q <= cfg_wdata_i;
      end
    end
  end

endmodule

[rtl/block_credit_ring_queue.sv]
// Top level of the credit ring queue: request register, result register, core and slot store.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------
//  request  | in_valid_i / in_ready_o | in_req_i   (bcrq_in_t)
//  result   | out_valid_o/ out_ready_i| out_rsp_o  (bcrq_out_t)
//  config   | cfg_we_i                | cfg_wdata_i (grant size)
//
// One request per cycle while results are taken and no clear sweep runs.
// A result passes the request register, the single-pass core and the result register.
// After reset the slot store is swept clear, with in_ready_o held low.
// A stalled result holds the result register; the request register still takes one more.
`include "block_credit_ring_queue_defines.svh"

module block_credit_ring_queue #(
  parameter int QUEUE_DEPTH = 1024,
  parameter int BLOCK_LEN   = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bcrq_pkg::bcrq_in_t  in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bcrq_pkg::bcrq_out_t out_rsp_o,
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_wdata_i
);
  import bcrq_pkg::*;

  localparam int SW = $clog2(QUEUE_DEPTH);

  logic          s1_valid_q;
  bcrq_in_t      s1_q;
  logic          out_valid_q;
  bcrq_out_t     out_q;
  logic          exec;
  logic          accept;
  logic          clr_busy;
  bcrq_out_t     rsp;
  logic [63:0]   head;
  logic          mem_we;
  logic [SW-1:0] mem_waddr;
  logic [63:0]   mem_wdata;
  logic [SW-1:0] mem_raddr;

  assign exec       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clr_busy && (!s1_valid_q || exec);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept || (s1_valid_q && !exec);
      if (exec) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= in_req_i;
    end
    if (exec) begin
      out_q <= rsp;
    end
  end

  bcrq_core #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .BLOCK_LEN  (BLOCK_LEN)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .exec_i     (exec),
    .req_i      (s1_q),
    .head_i     (head),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .rsp_o      (rsp),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr)
  );

  bcrq_slot_ram #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .head_o (head),
    .busy_o (clr_busy)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `BCRQ_ASSERT_IMP(a_no_req_in_sweep, clr_busy, !in_ready_o, "request taken during clear sweep")
  `BCRQ_ASSERT_IMP(a_fail_no_data, out_valid_o && out_rsp_o.status != ST_OK,
                   out_rsp_o.out_data == 64'd0, "data on failed request")
  `BCRQ_ASSERT_IMP(a_deq_nonzero, exec && s1_q.req_type == REQ_DEQ && rsp.status == ST_OK,
                   rsp.out_data != 64'd0, "empty word dequeued")
  `BCRQ_ASSERT_NXT(a_exec_fills_out, exec, out_valid_o, "result register not loaded")

endmodule
